// ===== rtl/core/mtrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrp_pkg
// shared types and codes of the modbus tcp response parser
// ----------------------------------------------------------------------------
package mtrp_pkg;

	localparam int          MAX_BIT_COUNT      = 2000;
	localparam int          QUEUE_DEPTH        = 2;
	localparam logic [10:0] RESULT_LIMIT_RESET = 11'd2000;

	// expected reply modes
	localparam logic [1:0] MODE_REG   = 2'd0;
	localparam logic [1:0] MODE_BIT   = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_MASK  = 2'd3;

	// function codes
	localparam logic [7:0] FC_RD_COILS    = 8'h01;
	localparam logic [7:0] FC_RD_DISCRETE = 8'h02;
	localparam logic [7:0] FC_RD_HOLDING  = 8'h03;
	localparam logic [7:0] FC_RD_INPUT    = 8'h04;
	localparam logic [7:0] FC_WR_COIL     = 8'h05;
	localparam logic [7:0] FC_WR_REG      = 8'h06;
	localparam logic [7:0] FC_WR_COILS    = 8'h0F;
	localparam logic [7:0] FC_WR_REGS     = 8'h10;
	localparam logic [7:0] FC_MASK_WRITE  = 8'h16;
	localparam logic [7:0] FC_RW_REGS     = 8'h17;

	// result kinds
	localparam logic [1:0] KIND_WORD   = 2'd0;
	localparam logic [1:0] KIND_BIT    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// frame status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_EXCEPTION = 2'd2;

	// work handed from front to back, one per accepted byte that causes results
	typedef struct packed {
		logic        has_word;
		logic        has_bits;
		logic        has_status;
		logic [10:0] index;
		logic [15:0] word;
		logic [7:0]  bits;
		logic [3:0]  nbits;
		logic [1:0]  status;
		logic [7:0]  exc_code;
		logic [15:0] count;
		logic [15:0] address;
		logic [15:0] keep_mask;
		logic [15:0] or_mask;
	} cmd_t;

endpackage

// ===== rtl/core/mtrp_front.sv =====
// ----------------------------------------------------------------------------
// mtrp_front
// byte parser: tracks frame position and header, decides what each byte emits
// ----------------------------------------------------------------------------
module mtrp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [23:0]   s_tdata,   // data_byte, bit_count
	input  logic [1:0]    s_tuser,   // mode
	input  logic          s_tlast,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [10:0]   cfg_data,
	output logic          push,
	output mtrp_pkg::cmd_t cmd,
	input  logic          full
);
	import mtrp_pkg::*;

	logic [10:0] limit_q;
	logic [8:0]  pos_q;
	logic [1:0]  mode_q;
	logic [7:0]  fc_q;
	logic [7:0]  dl_q;
	logic        hb_q;
	logic [7:0]  hold_q;
	logic [10:0] copied_q;
	logic [15:0] eb_q;
	logic [15:0] wa_q;
	logic [15:0] wb_q;
	logic [15:0] wc_q;

	logic        accept;
	logic [7:0]  byte_in;
	logic        first;
	logic [1:0]  mode_c;
	logic [15:0] eb_c;
	logic [10:0] copied_c;
	logic [7:0]  hold_c;
	logic        hb_n;
	logic [7:0]  fc_n;
	logic [7:0]  dl_n;
	logic [7:0]  hold_n;
	logic [10:0] copied_n;
	logic [15:0] wa_n;
	logic [15:0] wb_n;
	logic [15:0] wc_n;
	logic        fc_ok;
	logic        cnt_ok;
	logic [16:0] eb_plus7;
	logic [8:0]  off;
	logic        emit;
	logic [15:0] rem;
	logic [10:0] avail;
	logic [3:0]  nb;

	assign byte_in   = s_tdata[7:0];
	assign s_tready  = !full;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign first     = (pos_q == 9'd0);

	always_comb begin
		mode_c   = first ? s_tuser : mode_q;
		eb_c     = first ? s_tdata[23:8] : eb_q;
		copied_c = first ? 11'd0 : copied_q;
		hold_c   = first ? 8'd0 : hold_q;
		hb_n     = (first ? 1'b0 : hb_q) ||
		           ((pos_q == 9'd2 || pos_q == 9'd3) && byte_in != 8'd0);
		fc_n     = (pos_q == 9'd7) ? byte_in : (first ? 8'd0 : fc_q);
		dl_n     = (pos_q == 9'd8) ? byte_in : (first ? 8'd0 : dl_q);
		wa_n     = first ? 16'd0 : wa_q;
		wb_n     = first ? 16'd0 : wb_q;
		wc_n     = first ? 16'd0 : wc_q;
		if (pos_q == 9'd8 || pos_q == 9'd9)
			wa_n = {wa_n[7:0], byte_in};
		if (pos_q == 9'd10 || pos_q == 9'd11)
			wb_n = {wb_n[7:0], byte_in};
		if (pos_q == 9'd12 || pos_q == 9'd13)
			wc_n = {wc_n[7:0], byte_in};

		eb_plus7 = {1'b0, eb_c} + 17'd7;
		case (mode_c)
			MODE_REG: begin
				fc_ok  = fc_n inside {FC_RD_HOLDING, FC_RD_INPUT, FC_RW_REGS};
				cnt_ok = !dl_n[0];
			end
			MODE_BIT: begin
				fc_ok  = fc_n inside {FC_RD_COILS, FC_RD_DISCRETE};
				cnt_ok = (eb_c != 16'd0) && (eb_c <= 16'(MAX_BIT_COUNT)) &&
				         ({6'd0, dl_n} == eb_plus7[16:3]);
			end
			MODE_WRITE: begin
				fc_ok  = fc_n inside {FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS};
				cnt_ok = 1'b1;
			end
			default: begin
				fc_ok  = (fc_n == FC_MASK_WRITE);
				cnt_ok = 1'b1;
			end
		endcase

		off  = pos_q - 9'd9;
		emit = (pos_q >= 9'd9) && (off < {1'b0, dl_n}) && !mode_c[1] &&
		       !hb_n && fc_ok && cnt_ok;

		// bits left in this byte and room left under the limit
		rem   = eb_c - {4'd0, off, 3'b000};
		avail = (limit_q > copied_c) ? (limit_q - copied_c) : 11'd0;
		nb    = 4'd8;
		if (rem < 16'd8)
			nb = rem[3:0];
		if (avail < {7'd0, nb})
			nb = avail[3:0];

		hold_n = hold_c;
		cmd    = '0;
		cmd.index = copied_c;
		cmd.word  = {hold_c, byte_in};
		cmd.bits  = byte_in;
		cmd.nbits = nb;
		if (emit && mode_c == MODE_REG) begin
			if (!off[0])
				hold_n = byte_in;
			else if (copied_c < limit_q)
				cmd.has_word = 1'b1;
		end
		if (emit && mode_c == MODE_BIT && nb != 4'd0)
			cmd.has_bits = 1'b1;

		copied_n = copied_c;
		if (cmd.has_word)
			copied_n = copied_c + 11'd1;
		else if (cmd.has_bits)
			copied_n = copied_c + {7'd0, nb};

		// closing status
		cmd.has_status = s_tlast;
		cmd.status     = ST_MALFORMED;
		if (pos_q >= 9'd8 && !hb_n) begin
			if (fc_n[7]) begin
				cmd.status   = ST_EXCEPTION;
				cmd.exc_code = dl_n;
			end else if (fc_ok && cnt_ok) begin
				case (mode_c)
					MODE_REG, MODE_BIT: begin
						if ({1'b0, pos_q} >= 10'd8 + {2'd0, dl_n}) begin
							cmd.status = ST_OK;
							cmd.count  = {5'd0, copied_n};
						end
					end
					MODE_WRITE: begin
						if (pos_q >= 9'd11) begin
							cmd.status  = ST_OK;
							cmd.address = wa_n;
							cmd.count   = (fc_n == FC_WR_COIL || fc_n == FC_WR_REG) ?
							              16'd1 : wb_n;
						end
					end
					default: begin
						if (pos_q >= 9'd13) begin
							cmd.status    = ST_OK;
							cmd.address   = wa_n;
							cmd.keep_mask = wb_n;
							cmd.or_mask   = wc_n;
							cmd.count     = 16'd1;
						end
					end
				endcase
			end
		end

		push = accept && (cmd.has_word || cmd.has_bits || cmd.has_status);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= RESULT_LIMIT_RESET;
			pos_q    <= 9'd0;
			mode_q   <= MODE_REG;
			fc_q     <= 8'd0;
			dl_q     <= 8'd0;
			hb_q     <= 1'b0;
			hold_q   <= 8'd0;
			copied_q <= 11'd0;
			eb_q     <= 16'd0;
			wa_q     <= 16'd0;
			wb_q     <= 16'd0;
			wc_q     <= 16'd0;
		end else begin
			if (cfg_valid)
				limit_q <= cfg_data;
			if (accept) begin
				mode_q   <= mode_c;
				eb_q     <= eb_c;
				fc_q     <= fc_n;
				dl_q     <= dl_n;
				hb_q     <= hb_n;
				hold_q   <= hold_n;
				copied_q <= copied_n;
				wa_q     <= wa_n;
				wb_q     <= wb_n;
				wc_q     <= wc_n;
				if (s_tlast)
					pos_q <= 9'd0;
				else if (pos_q != 9'h1FF)
					pos_q <= pos_q + 9'd1;
			end
		end
	end

endmodule

// ===== rtl/core/mtrp_queue.sv =====
// ----------------------------------------------------------------------------
// mtrp_queue
// short command queue between parser front and result back end
// ----------------------------------------------------------------------------
module mtrp_queue #(
	parameter int DEPTH = mtrp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtrp_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output mtrp_pkg::cmd_t head,
	output logic           empty
);
	import mtrp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count overrun");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && empty) |=> !empty)
		else $error("pushed item lost");
`endif

endmodule

// ===== rtl/core/mtrp_back.sv =====
// ----------------------------------------------------------------------------
// mtrp_back
// result sequencer: expands queued commands into words, bits and status
// ----------------------------------------------------------------------------
module mtrp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mtrp_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [103:0]   m_tdata,  // item_index, word_value, bit_value, status,
	                                 // exception_code, result_count, echoed_address,
	                                 // keep_mask, or_mask, zero pad
	output logic [1:0]     m_tuser,  // kind
	output logic           m_tlast
);
	import mtrp_pkg::*;

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [10:0] index_q;
	logic [15:0] word_q;
	logic        bit_q;
	logic [1:0]  st_q;
	logic [7:0]  exc_q;
	logic [15:0] cnt_q;
	logic [15:0] addr_q;
	logic [15:0] am_q;
	logic [15:0] om_q;
	logic        last_q;
	logic [2:0]  bcnt_q;
	logic        done_q;

	logic load;
	logic in_data;
	logic data_end;

	assign load     = !empty && (!valid_q || m_tready);
	assign in_data  = (head.has_word || head.has_bits) && !done_q;
	assign data_end = head.has_word || ({1'b0, bcnt_q} == head.nbits - 4'd1);
	assign pop      = load && (in_data ? (data_end && !head.has_status) : 1'b1);

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {2'b00, om_q, am_q, addr_q, cnt_q, exc_q, st_q,
	                   bit_q, word_q, index_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			bcnt_q  <= 3'd0;
			done_q  <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
			if (load && in_data && head.has_bits)
				bcnt_q <= data_end ? 3'd0 : bcnt_q + 3'd1;
			if (load && in_data && data_end && head.has_status)
				done_q <= 1'b1;
			else if (pop)
				done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			st_q   <= ST_OK;
			exc_q  <= 8'd0;
			cnt_q  <= 16'd0;
			addr_q <= 16'd0;
			am_q   <= 16'd0;
			om_q   <= 16'd0;
			last_q <= 1'b0;
			if (in_data && head.has_word) begin
				kind_q  <= KIND_WORD;
				index_q <= head.index;
				word_q  <= head.word;
				bit_q   <= 1'b0;
			end else if (in_data) begin
				kind_q  <= KIND_BIT;
				index_q <= head.index + {8'd0, bcnt_q};
				word_q  <= 16'd0;
				bit_q   <= head.bits[bcnt_q];
			end else begin
				kind_q  <= KIND_STATUS;
				index_q <= 11'd0;
				word_q  <= 16'd0;
				bit_q   <= 1'b0;
				st_q    <= head.status;
				exc_q   <= head.exc_code;
				cnt_q   <= head.count;
				addr_q  <= head.address;
				am_q    <= head.keep_mask;
				om_q    <= head.or_mask;
				last_q  <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_bcnt_in_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(bcnt_q != 3'd0) |-> (!empty && head.has_bits && !done_q))
		else $error("bit counter running without a bit command");
	a_done_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!empty && head.has_status))
		else $error("data finished but no status pending");
`endif

endmodule

// ===== rtl/core/modbus_tcp_response_parser.sv =====
// ----------------------------------------------------------------------------
// modbus_tcp_response_parser
// The parser takes one response byte per item and accepts a new byte in every
// cycle while its command queue (QUEUE_DEPTH entries) has room. A register
// word, a status result or a write echo is registered in the back end's output
// stage once its command reaches the back end and the output is free; a coil
// or input byte expands to up to eight bit results, one per cycle from the
// back-end sequencer while the output accepts them, so that sequencer sets the
// sustained rate in bit mode. When the closing byte also carries a word or
// bits, those results leave before its status. Word and bit results are
// provisional until the status of their frame says ok. result_limit may be
// written only while idle.
// ----------------------------------------------------------------------------
module modbus_tcp_response_parser #(
	parameter int QUEUE_DEPTH = mtrp_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // data_byte, bit_count
	input  logic [1:0]   s_tuser,   // mode
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // item_index, word_value, bit_value, status,
	                                // exception_code, result_count, echoed_address,
	                                // keep_mask, or_mask, zero pad
	output logic [1:0]   m_tuser,   // kind
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [10:0]  cfg_data
);
	import mtrp_pkg::*;

	cmd_t wr_cmd;
	cmd_t head;
	logic push;
	logic full;
	logic pop;
	logic empty;

	mtrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.cmd       (wr_cmd),
		.full      (full)
	);

	mtrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	mtrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
